// ===== sv/articulation_point_finder_assert.svh =====
// Assertion macros for the articulation point finder.
// Used by articulation_point_finder.sv; no other dependencies.
`ifndef ARTICULATION_POINT_FINDER_ASSERT_SVH
`define ARTICULATION_POINT_FINDER_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define APF_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication checked outside reset.
`define APF_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== sv/apf_pkg.sv =====
// Package for the articulation point finder: sizes, opcodes, parent codes.
// No dependencies.
package apf_pkg;
  localparam int NV = 32;
  localparam int VW = 5;
  localparam int TW = 7;
  localparam int CW = 6;
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_RUN = 2'd1;
  localparam logic [1:0] OP_CLR = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [6:0] PAR_ROOT = 7'h7E;
  localparam logic [6:0] PAR_NONE = 7'h7F;
  // per-vertex search record, held in one memory word
  typedef struct packed {
    logic [TW-1:0] disc;
    logic [TW-1:0] low;
    logic [6:0]    par;
    logic [CW-1:0] cnt;
  } vrec_t;
endpackage

// ===== sv/articulation_point_finder.sv =====
// Articulation point finder: adjacency rows plus an iterative depth-first
// low-link search over a per-vertex record memory.
// Depends on apf_pkg and articulation_point_finder_assert.svh.
//
// channel  dir  tdata bits                  tuser         tlast
// in_      in   [4:0] from [9:5] to         [1:0] opcode  -
// out_     out  [4:0] vertex                [0] found     last
// cfg_     in   [5:0] num_vertices          -             -
//
// Add-arc and clear beats finish in the accept cycle. A run scans for unvisited
// roots, descends along each tree arc, reads each other visited neighbour to
// lower the low-link, pops each finished vertex and folds its low-link into
// its parent, then sweeps out the report beats. in_tready and cfg_ready are
// high only when idle; out_tready stalls hold the report sweep. rst_n clears
// control state and the adjacency rows and sets the vertex count to 32.
`include "articulation_point_finder_assert.svh"
module articulation_point_finder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // from_vertex, to_vertex
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // vertex
  output logic        out_tuser,  // found
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROOT = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_BACK = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;
  localparam logic [2:0] S_REP  = 3'd5;

  logic [2:0] st_r;
  logic [5:0] nv_r;
  logic [apf_pkg::NV-1:0] adj_r [apf_pkg::NV];
  logic [apf_pkg::NV-1:0] vis_r;
  logic [apf_pkg::NV-1:0] cutv_r;
  apf_pkg::vrec_t rec_mem [apf_pkg::NV];
  apf_pkg::vrec_t rd_q_r;
  apf_pkg::vrec_t top_r;   // record of the vertex on top of the stack
  apf_pkg::vrec_t child_rec;
  apf_pkg::vrec_t pop_rec;
  logic rd_en;
  logic [apf_pkg::VW-1:0] rd_a;
  logic wr_en;
  logic [apf_pkg::VW-1:0] wr_a;
  apf_pkg::vrec_t wr_d;
  // stack: vertex and next neighbour per level
  logic [apf_pkg::VW-1:0] sv_r [apf_pkg::NV];
  logic [5:0] sn_r [apf_pkg::NV];
  logic [5:0] sp_r;
  logic [apf_pkg::VW-1:0] tos;
  logic [5:0] idx_r;
  logic [apf_pkg::TW-1:0] clk_r;
  logic [apf_pkg::TW-1:0] clow_r; // low of child just popped
  logic [5:0] n_eff;
  logic [apf_pkg::VW-1:0] u;
  logic [apf_pkg::VW-1:0] pv;
  logic [apf_pkg::NV-1:0] cand;
  logic w_ok;
  logic [apf_pkg::VW-1:0] w;
  logic out_v_r, out_l_r, out_f_r;
  logic [apf_pkg::VW-1:0] out_x_r;
  logic [apf_pkg::VW-1:0] nxt_cut;
  logic nxt_has;
  logic [apf_pkg::NV-1:0] later;
  logic [apf_pkg::NV-1:0] others;

  assign n_eff = (nv_r > 6'(apf_pkg::NV)) ? 6'(apf_pkg::NV) : nv_r;
  assign in_tready = (st_r == S_IDLE);
  assign cfg_ready = (st_r == S_IDLE);
  assign tos = sp_r[4:0] - 5'd1;
  assign u = sv_r[tos];
  assign pv = sv_r[sp_r[4:0] - 5'd2];

  // next neighbour at or above the top's scan index, below n
  always_comb begin
    cand = '0;
    w_ok = 1'b0;
    w = '0;
    for (int i = apf_pkg::NV - 1; i >= 0; i--) begin
      cand[i] = adj_r[u][i] && (6'(i) >= sn_r[tos]) && (6'(i) < n_eff);
      if (cand[i]) begin
        w_ok = 1'b1;
        w = 5'(i);
      end
    end
  end

  // next cut vertex at or above idx, and whether more follow it
  always_comb begin
    nxt_has = 1'b0;
    nxt_cut = '0;
    later = '0;
    for (int i = apf_pkg::NV - 1; i >= 0; i--) begin
      later[i] = cutv_r[i] && (6'(i) >= idx_r) && (6'(i) < n_eff);
      if (later[i]) begin
        nxt_has = 1'b1;
        nxt_cut = 5'(i);
      end
    end
    others = later;
    others[nxt_cut] = 1'b0;
  end

  // fresh record for a child, and the parent record after a child returns
  always_comb begin
    child_rec = '{disc: clk_r + 7'd1, low: clk_r + 7'd1, par: {2'b0, u}, cnt: '0};
    pop_rec = rd_q_r;
    if (rd_q_r.low > clow_r) pop_rec.low = clow_r;
  end

  // record memory: one read, one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) rec_mem[wr_a] <= wr_d;
    if (rd_en) rd_q_r <= rec_mem[rd_a];
  end

  // memory traffic: the top is saved when it gets a child or finishes;
  // visited neighbours and the parent are read. No entry is read and
  // written in the same cycle, so no forwarding is needed.
  always_comb begin
    rd_en = 1'b0;
    rd_a = w;
    wr_en = 1'b0;
    wr_a = u;
    wr_d = top_r;
    if (st_r == S_STEP) begin
      if (w_ok && !vis_r[w]) begin
        wr_en = 1'b1;
        if (top_r.cnt != 6'd63) wr_d.cnt = top_r.cnt + 6'd1;
      end else if (w_ok) begin
        rd_en = (w != u);
      end else begin
        wr_en = 1'b1;
        rd_en = (sp_r != 6'd1);
        rd_a = pv;
      end
    end
  end

  // control and search state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      nv_r <= 6'd32;
      sp_r <= '0;
      for (int i = 0; i < apf_pkg::NV; i++) adj_r[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) nv_r <= cfg_data;
      case (st_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            case (in_tuser)
              apf_pkg::OP_ADD: adj_r[in_tdata[4:0]][in_tdata[9:5]] <= 1'b1;
              apf_pkg::OP_CLR: for (int i = 0; i < apf_pkg::NV; i++) adj_r[i] <= '0;
              apf_pkg::OP_RUN: begin
                // records are rewritten on entry, so only the marks clear
                vis_r <= '0;
                cutv_r <= '0;
                clk_r <= '0;
                idx_r <= '0;
                sp_r <= '0;
                st_r <= S_ROOT;
              end
              default: ;
            endcase
          end
        end
        S_ROOT: begin
          if (idx_r >= n_eff) begin
            idx_r <= '0;
            st_r <= S_REP;
          end else if (vis_r[idx_r[4:0]]) begin
            idx_r <= idx_r + 6'd1;
          end else begin
            vis_r[idx_r[4:0]] <= 1'b1;
            clk_r <= clk_r + 7'd1;
            top_r <= '{disc: clk_r + 7'd1, low: clk_r + 7'd1, par: apf_pkg::PAR_ROOT,
                       cnt: '0};
            sv_r[0] <= idx_r[4:0];
            sn_r[0] <= '0;
            sp_r <= 6'd1;
            idx_r <= idx_r + 6'd1;
            st_r <= S_STEP;
          end
        end
        S_STEP: begin
          if (w_ok) begin
            sn_r[tos] <= {1'b0, w} + 6'd1;
            if (!vis_r[w]) begin
              // descend into the new child
              vis_r[w] <= 1'b1;
              clk_r <= clk_r + 7'd1;
              top_r <= child_rec;
              sv_r[sp_r[4:0]] <= w;
              sn_r[sp_r[4:0]] <= '0;
              sp_r <= sp_r + 6'd1;
            end else if (w != u) begin
              st_r <= S_BACK;
            end
          end else begin
            // top finished: leave it
            clk_r <= clk_r + 7'd1;
            if (top_r.par == apf_pkg::PAR_ROOT && top_r.cnt > 6'd1) cutv_r[u] <= 1'b1;
            clow_r <= top_r.low;
            sp_r <= sp_r - 6'd1;
            st_r <= (sp_r == 6'd1) ? S_ROOT : S_POP;
          end
        end
        S_BACK: begin
          if (top_r.low > rd_q_r.disc) top_r.low <= rd_q_r.disc;
          st_r <= S_STEP;
        end
        S_POP: begin
          // parent is back on top; fold in the child's low-link
          top_r <= pop_rec;
          if (rd_q_r.par != apf_pkg::PAR_ROOT && rd_q_r.disc <= clow_r) cutv_r[u] <= 1'b1;
          st_r <= S_STEP;
        end
        S_REP: begin
          if (!out_v_r || out_tready) begin
            if (nxt_has) begin
              idx_r <= {1'b0, nxt_cut} + 6'd1;
              if (others == '0) st_r <= S_IDLE;
            end else begin
              st_r <= S_IDLE;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // report beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (st_r == S_REP && (!out_v_r || out_tready)) begin
      out_v_r <= 1'b1;
      out_x_r <= nxt_has ? nxt_cut : '0;
      out_f_r <= nxt_has;
      out_l_r <= !nxt_has || (others == '0);
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = {3'b0, out_x_r};
  assign out_tuser = out_f_r;
  assign out_tlast = out_l_r;

  `APF_ASSERT_IMP(a_in_idle, clk, rst_n, in_tready, st_r == S_IDLE, "ready outside idle")
  `APF_ASSERT_IMP(a_cfg_idle, clk, rst_n, cfg_ready, st_r == S_IDLE, "config outside idle")
  `APF_ASSERT_IMP(a_sp_rng, clk, rst_n, 1'b1, sp_r <= 6'(apf_pkg::NV), "stack overflow")
  `APF_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "beat dropped")
endmodule

// ===== test/tb.sv =====
// Testbench for articulation_point_finder: graph loads, clears and cut-vertex searches.
// Depends on apf_pkg and the articulation_point_finder RTL; expected results come from
// a behavioral depth-first search kept in this file.
module tb;
  typedef struct packed {
    logic [1:0] op;
    logic [4:0] src;
    logic [4:0] dst;
  } cmd_t;

  typedef struct packed {
    logic [4:0] vertex;
    logic       found;
    logic       last;
  } cut_t;

  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;

  articulation_point_finder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [apf_pkg::NV-1:0] graph_rows [apf_pkg::NV];
  logic [5:0]    vert_count;
  cmd_t          pending_cmds [$];
  cut_t          cut_queue [$];
  int            fail_cnt = 0;
  int            idle_pct = 30;
  int            hold_cycles = 0;
  bit            feeding = 1'b0;
  int            quiet_cycles = 0;

  // Tarjan search: visited neighbors, the parent too, lower the low-link.
  task automatic predict_cuts();
    int n, sp, r, u, w, p, cnt;
    int disc [apf_pkg::NV];
    int low [apf_pkg::NV];
    int kids [apf_pkg::NV];
    bit seen [apf_pkg::NV];
    bit is_root [apf_pkg::NV];
    bit cut [apf_pkg::NV];
    int stk_v [apf_pkg::NV];
    int stk_n [apf_pkg::NV];
    int tick;
    n = (vert_count > apf_pkg::NV) ? apf_pkg::NV : vert_count;
    tick = 0;
    sp = 0;
    for (int i = 0; i < apf_pkg::NV; i++) begin
      disc[i] = 0; low[i] = 0; kids[i] = 0; seen[i] = 0; is_root[i] = 0; cut[i] = 0;
    end
    for (r = 0; r < n; r++) begin
      if (seen[r]) continue;
      is_root[r] = 1;
      seen[r] = 1; tick++; disc[r] = tick; low[r] = tick;
      stk_v[0] = r; stk_n[0] = 0; sp = 1;
      while (sp > 0) begin
        u = stk_v[sp-1];
        w = stk_n[sp-1];
        while (w < n && !graph_rows[u][w]) w++;
        if (w < n) begin
          stk_n[sp-1] = w + 1;
          if (!seen[w]) begin
            kids[u]++;
            seen[w] = 1; tick++; disc[w] = tick; low[w] = tick;
            stk_v[sp] = w; stk_n[sp] = 0; sp++;
          end else if (low[u] > disc[w]) begin
            low[u] = disc[w];
          end
        end else begin
          sp--; tick++;
          if (is_root[u] && kids[u] > 1) cut[u] = 1;
          if (sp > 0) begin
            p = stk_v[sp-1];
            if (low[p] > low[u]) low[p] = low[u];
            if (!is_root[p] && disc[p] <= low[u]) cut[p] = 1;
          end
        end
      end
    end
    cnt = 0;
    for (int v = 0; v < n; v++) begin
      if (cut[v]) begin
        cut_queue.push_back('{vertex: v[4:0], found: 1'b1, last: 1'b0});
        cnt++;
      end
    end
    if (cnt == 0) cut_queue.push_back('{vertex: 5'd0, found: 1'b0, last: 1'b1});
    else cut_queue[cut_queue.size()-1].last = 1'b1;
  endtask

  task automatic apply_cmd(cmd_t c);
    case (c.op)
      apf_pkg::OP_ADD: graph_rows[c.src][c.dst] = 1'b1;
      apf_pkg::OP_CLR: for (int i = 0; i < apf_pkg::NV; i++) graph_rows[i] = '0;
      apf_pkg::OP_RUN: predict_cuts();
      default: ;
    endcase
  endtask

  // driver: one beat per accepted item, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_tready) begin
      // hold the offered beat
    end else begin
      if (in_tvalid) begin
        apply_cmd(pending_cmds.pop_front());
      end
      if (feeding && pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= {6'd0, pending_cmds[0].dst, pending_cmds[0].src};
        in_tuser <= pending_cmds[0].op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    cut_t exp_cut;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (cut_queue.size() == 0) begin
          $error("result with nothing expected: vertex %0d", out_tdata[4:0]);
          fail_cnt++;
        end else begin
          exp_cut = cut_queue.pop_front();
          if (out_tdata[4:0] !== exp_cut.vertex) begin
            $error("vertex: expected %0d, got %0d", exp_cut.vertex, out_tdata[4:0]);
            fail_cnt++;
          end
          if (out_tuser !== exp_cut.found) begin
            $error("found: expected %0d, got %0d", exp_cut.found, out_tuser);
            fail_cnt++;
          end
          if (out_tlast !== exp_cut.last) begin
            $error("last: expected %0d, got %0d", exp_cut.last, out_tlast);
            fail_cnt++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic cmd_t arc(int a, int b);
    return '{op: apf_pkg::OP_ADD, src: a[4:0], dst: b[4:0]};
  endfunction

  task automatic queue_edge(int a, int b);
    pending_cmds.push_back(arc(a, b));
    pending_cmds.push_back(arc(b, a));
  endtask

  task automatic queue_op(logic [1:0] op);
    pending_cmds.push_back('{op: op, src: 5'($urandom), dst: 5'($urandom)});
  endtask

  // release queued items and wait until all are accepted and answered
  task automatic drain();
    feeding = 1'b1;
    while (pending_cmds.size() > 0 || cut_queue.size() > 0) @(posedge clk);
    feeding = 1'b0;
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(logic [5:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    vert_count = val;
    cfg_valid <= 1'b0;
  endtask

  // random graph: mostly undirected paths/cycles/trees with a few stray arcs
  task automatic queue_random_graph(int n);
    int k;
    queue_op(apf_pkg::OP_CLR);
    k = $urandom_range(3);
    for (int i = 1; i < n; i++) begin
      if (k == 0) queue_edge(i - 1, i);
      else if (k == 1) queue_edge($urandom_range(i - 1), i);
      else if ($urandom_range(2) != 0) queue_edge($urandom_range(i - 1), i);
    end
    repeat ($urandom_range(3)) queue_edge($urandom_range(n - 1), $urandom_range(n - 1));
    if ($urandom_range(4) == 0) pending_cmds.push_back(arc($urandom_range(31), $urandom_range(31)));
    if ($urandom_range(6) == 0) queue_op(apf_pkg::OP_NONE);
    queue_op(apf_pkg::OP_RUN);
  endtask

  initial begin
    int n;
    for (int i = 0; i < apf_pkg::NV; i++) graph_rows[i] = '0;
    vert_count = 6'd32;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty graph, star, path, stray opcode and out-of-range arcs
    queue_op(apf_pkg::OP_RUN);
    for (int i = 1; i < 32; i++) pending_cmds.push_back(arc(0, i));
    for (int i = 1; i < 32; i++) pending_cmds.push_back(arc(i, 0));
    queue_op(apf_pkg::OP_RUN);
    queue_op(apf_pkg::OP_NONE);
    drain();
    write_count(6'd5);
    queue_op(apf_pkg::OP_CLR);
    queue_edge(0, 1); queue_edge(1, 2); queue_edge(2, 3); queue_edge(3, 4);
    pending_cmds.push_back(arc(31, 31));
    queue_op(apf_pkg::OP_RUN);
    drain();
    write_count(6'd0);
    queue_op(apf_pkg::OP_RUN);
    drain();
    write_count(6'd1);
    queue_op(apf_pkg::OP_RUN);
    drain();
    write_count(6'd63);
    queue_op(apf_pkg::OP_RUN);
    drain();

    // receiver hold-off while runs pile up
    write_count(6'd32);
    hold_cycles = 3000;
    for (int i = 0; i < 2; i++) queue_random_graph(12);
    drain();

    // random phases; one stretch without idling
    for (int ph = 0; ph < 6; ph++) begin
      n = (ph % 3 == 0) ? $urandom_range(16, 1) : $urandom_range(8, 2);
      write_count(n[5:0]);
      idle_pct = (ph == 4) ? 0 : 30;
      for (int g = 0; g < 3; g++) queue_random_graph(n);
      drain();
    end
    idle_pct = 30;

    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
